/* design/slab_index_free_list_allocator_defines.svh */
// Assertion macros used by the allocator checker.
`ifndef SLAB_INDEX_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLAB_INDEX_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define SFLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sfla_pkg.sv */
// Shared types and constants of the slab index free-list allocator.
package sfla_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 17;
	localparam int SLOT_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int PROD_W    = SIZE_W + SLOT_W;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP  = 2'd2;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic              clr;
		logic [SLOT_W-1:0] addr;
		logic [SLOT_W-1:0] wdata;
	} link_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* design/sfla_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module sfla_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sfla_pkg::ADDR_W-1:0]  dividend,
	input  logic [sfla_pkg::SIZE_W-1:0]  divisor,
	output sfla_pkg::div_stat_t          stat,
	output logic [sfla_pkg::ADDR_W-1:0]  quotient
);
	import sfla_pkg::*;

	localparam int CNT_W = $clog2(ADDR_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ADDR_W - 1);

	logic [SIZE_W-1:0] rem_q;
	logic [ADDR_W-1:0] quo_q;
	logic [SIZE_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;

	assign trial = {rem_q, quo_q[ADDR_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dsr_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[SIZE_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[SIZE_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

/* design/sfla_link_ram.sv */
// Next-slot link table with per-entry valid bits for the reset chain.
module sfla_link_ram #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfla_pkg::link_req_t          req,
	output logic [sfla_pkg::SLOT_W-1:0]  rdata
);
	import sfla_pkg::*;

	localparam int MEM_DEPTH = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
	localparam int IDX_W     = $clog2(MEM_DEPTH);
	localparam logic [SLOT_W:0] DEPTH_C = (SLOT_W + 1)'(MEM_DEPTH);

	logic [SLOT_W-1:0]    mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;
	logic [SLOT_W-1:0]    mem_rd_q;
	logic [SLOT_W-1:0]    init_rd_q;
	logic                 valid_rd_q;
	logic                 hit_rd_q;
	logic                 in_range;
	logic [IDX_W-1:0]     idx;

	assign in_range = {1'b0, req.addr} < DEPTH_C;
	assign idx      = req.addr[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en && in_range) begin
			mem[idx] <= req.wdata;
		end
		if (req.rd_en) begin
			mem_rd_q  <= mem[idx];
			init_rd_q <= req.addr + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
			hit_rd_q   <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en && in_range) begin
				valid_q[idx] <= 1'b1;
			end
			if (req.rd_en) begin
				valid_rd_q <= valid_q[idx];
				hit_rd_q   <= in_range;
			end
		end
	end

	always_comb begin
		if (!hit_rd_q) begin
			rdata = '0;
		end else if (valid_rd_q) begin
			rdata = mem_rd_q;
		end else begin
			rdata = init_rd_q;
		end
	end

endmodule

/* design/slab_index_free_list_allocator.sv */
// Slab allocator: hands out and takes back fixed-size objects through a free
// list of slot indexes. One request at a time; s_tready is low while a request
// is in work. An allocate reads the link table, multiplies and adds before it
// answers; a free waits for the 32-step divider that turns the address offset
// into a slot number. Errors found when a request is taken go straight to the
// done state; a broken chain on allocate is found after the link table read.
// s_tready rises with the answer. A finished result waits in the output
// register while the next request is taken. Writing capacity reloads the
// chain by clearing the link table's valid bits, so there is no clearing
// pass after reset.
module slab_index_free_list_allocator #(
	parameter int MAX_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // free_address
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // object_address, slot_index, live_objects
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import sfla_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LINK,
		S_ADDR,
		S_DIV,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [SLOT_W-1:0] cap_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] live_q;
	logic [SLOT_W-1:0] link_q;
	logic [PROD_W-1:0] prod_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [SLOT_W-1:0] res_live_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [SLOT_W-1:0] out_live_q;
	logic              out_valid_q;

	logic              s_accept;
	logic              div_start;
	logic [ADDR_W-1:0] offset;
	div_stat_t         div_stat;
	logic [ADDR_W-1:0] quotient;
	link_req_t         link_req;
	logic [SLOT_W-1:0] link_rdata;
	logic              quo_ok;
	logic              out_free;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign offset   = s_tdata - base_q;
	assign quo_ok   = (quotient <= {{(ADDR_W - SLOT_W){1'b0}}, cap_q});
	assign out_free = !out_valid_q || m_tready;

	assign div_start = s_accept && (s_tuser == REQ_FREE) && (live_q != '0)
		&& (size_q != '0) && (s_tdata >= base_q);

	always_comb begin
		link_req.rd_en = s_accept && (s_tuser == REQ_ALLOC) && (live_q != cap_q)
			&& (head_q <= cap_q);
		link_req.wr_en = (state_q == S_DIV) && div_stat.done && quo_ok;
		link_req.clr   = cfg_we && (cfg_index == REG_CAP);
		link_req.addr  = (state_q == S_DIV) ? quotient[SLOT_W-1:0] : head_q;
		link_req.wdata = head_q;
	end

	sfla_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (offset),
		.divisor  (size_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	sfla_link_ram #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (link_req),
		.rdata  (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= '0;
			size_q       <= SIZE_W'(4);
			cap_q        <= '1;
			head_q       <= '0;
			live_q       <= '0;
			link_q       <= '0;
			prod_q       <= '0;
			res_status_q <= ST_OK;
			res_addr_q   <= '0;
			res_slot_q   <= '0;
			res_live_q   <= '0;
			out_status_q <= ST_OK;
			out_addr_q   <= '0;
			out_slot_q   <= '0;
			out_live_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE: base_q <= cfg_wdata;
					REG_SIZE: size_q <= cfg_wdata[SIZE_W-1:0];
					REG_CAP: begin
						cap_q  <= cfg_wdata[SLOT_W-1:0];
						head_q <= '0;
						live_q <= '0;
					end
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						res_addr_q <= '0;
						res_slot_q <= '0;
						res_live_q <= live_q;
						if (s_tuser == REQ_ALLOC) begin
							if (live_q == cap_q || head_q > cap_q) begin
								res_status_q <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_LINK;
							end
						end else if (live_q == '0) begin
							res_status_q <= ST_EMPTY;
							state_q      <= S_DONE;
						end else if (!div_start) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_LINK: begin
					link_q <= link_rdata;
					prod_q <= size_q * head_q;
					if (link_rdata > cap_q) begin
						res_status_q <= ST_FULL;
						state_q      <= S_DONE;
					end else if (size_q == '0) begin
						res_status_q <= ST_RANGE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					res_status_q <= ST_OK;
					res_addr_q   <= base_q + {{(ADDR_W - PROD_W){1'b0}}, prod_q};
					res_slot_q   <= head_q;
					res_live_q   <= live_q + 1'b1;
					head_q       <= link_q;
					live_q       <= live_q + 1'b1;
					state_q      <= S_DONE;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (quo_ok) begin
							res_status_q <= ST_OK;
							res_slot_q   <= quotient[SLOT_W-1:0];
							res_live_q   <= live_q - 1'b1;
							head_q       <= quotient[SLOT_W-1:0];
							live_q       <= live_q - 1'b1;
						end else begin
							res_status_q <= ST_RANGE;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						out_slot_q   <= res_slot_q;
						out_live_q   <= res_live_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_live_q, out_slot_q, out_addr_q};

endmodule

/* design/sfla_checker.sv */
// Port-level checks of the allocator, bound to the top level.
`include "slab_index_free_list_allocator_defines.svh"

module sfla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [31:0] cfg_wdata
);
	import sfla_pkg::*;

	`SFLA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid,
		"result dropped while stalled")

	`SFLA_ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"request taken while previous one in work")

	`SFLA_ASSERT_NOW(a_err_zero, clk, arst_n, m_tvalid && (m_tuser != ST_OK),
		m_tdata[39:0] == 40'd0, "error result carries address or slot")

	`SFLA_ASSERT_NOW(a_empty_live, clk, arst_n, m_tvalid && (m_tuser == ST_EMPTY),
		m_tdata[47:40] == 8'd0, "nothing-allocated result with live objects")

endmodule

bind slab_index_free_list_allocator sfla_checker u_sfla_checker (.*);
